// ===== rtl/core/btep_pkg.sv =====
package btep_pkg;

    // Fraction bits of the Q2.14 coordinate format
    localparam int Q_FRAC = 14;

    // Digit width of the shared multiplier (one digit per cycle)
    localparam int DIGIT_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POINTS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOVE_THRESHOLD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STALE_WINDOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_BOUND     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLAT_EPSILON   = 3'd4;

    // Register reset values
    localparam logic [3:0]  RST_FIT_POINTS     = 4'd5;
    localparam logic [14:0] RST_MOVE_THRESHOLD = 15'd410;
    localparam logic [23:0] RST_STALE_WINDOW   = 24'd100000;
    localparam logic [14:0] RST_EDGE_BOUND     = 15'd13926;
    localparam logic [7:0]  RST_FLAT_EPSILON   = 8'd2;

    // Input item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_PREDICT = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_STILL = 2'd1;
    localparam logic [1:0] STAT_FEW   = 2'd2;

    // Shared unit operations
    localparam logic MDU_MUL = 1'b0;
    localparam logic MDU_DIV = 1'b1;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic op;
    } t_mdu_req;

endpackage

// ===== rtl/core/btep_ram.sv =====
module btep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/btep_mdu.sv =====
module btep_mdu #(
    parameter int WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  btep_pkg::t_mdu_req      i_req,
    input  logic signed [WIDTH-1:0] i_a,
    input  logic signed [WIDTH-1:0] i_b,
    output logic                    o_done,
    output logic signed [WIDTH-1:0] o_result
);

    localparam int DW     = btep_pkg::DIGIT_W;
    localparam int STEPS  = WIDTH / DW;
    localparam int CNT_W  = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_op;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;

    logic [WIDTH-1:0] w_a_mag;
    logic [WIDTH-1:0] w_b_mag;
    logic [WIDTH-1:0] w_rem_sh;
    logic [WIDTH-1:0] w_mag;

    assign w_a_mag  = i_a[WIDTH-1] ? WIDTH'(-i_a) : WIDTH'(i_a);
    assign w_b_mag  = i_b[WIDTH-1] ? WIDTH'(-i_b) : WIDTH'(i_b);
    assign w_rem_sh = {r_acc[WIDTH-2:0], r_a[WIDTH-1]};

    // Control: start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == btep_pkg::MDU_MUL) ? CNT_W'(STEPS) : CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one digit product or one quotient bit per cycle on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_a[WIDTH-1] ^ i_b[WIDTH-1];
            r_a   <= w_a_mag;
            r_b   <= w_b_mag;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_op == btep_pkg::MDU_MUL) begin
                r_acc <= r_acc + WIDTH'(r_a * r_b[DW-1:0]);
                r_a   <= r_a << DW;
                r_b   <= r_b >> DW;
            end else if (w_rem_sh >= r_b) begin
                r_acc <= w_rem_sh - r_b;
                r_a   <= {r_a[WIDTH-2:0], 1'b1};
            end else begin
                r_acc <= w_rem_sh;
                r_a   <= {r_a[WIDTH-2:0], 1'b0};
            end
        end
    end

    // Restore the sign; division truncates toward zero
    assign w_mag    = (r_op == btep_pkg::MDU_MUL) ? r_acc : r_a;
    assign o_result = r_neg ? $signed(-w_mag) : $signed(w_mag);
    assign o_done   = r_done;

endmodule

// ===== rtl/core/ball_trajectory_edge_predictor.sv =====
// Sample beat: written directly when the history is empty, else after three products.
// Predict beat: early exits skip the shared unit; the full fit over n entries and the two-point
// fit run on the shared unit, which multiplies digit by digit and divides bit by bit.
// One beat at a time: input ready only while idle; the result waits in an output register.
// Synchronous active-low reset empties the history and loads register defaults.
module ball_trajectory_edge_predictor #(
    parameter int HISTORY_DEPTH = 10,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input beat
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: ball_x, ball_y, now_ticks (from bit 0 up)
    input  logic [8*((2*COORD_WIDTH+39)/8)-1:0] s_axis_tdata,
    // tuser: kind
    input  logic                                s_axis_tuser,
    // Result beat
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: pred_x, pred_y (from bit 0 up)
    output logic [8*((2*COORD_WIDTH+7)/8)-1:0]  m_axis_tdata,
    // tuser: status
    output logic [1:0]                          m_axis_tuser,
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [btep_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [btep_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int IN_W   = 8 * ((2 * CW + 39) / 8);
    localparam int OUT_W  = 8 * ((2 * CW + 7) / 8);
    localparam int DW     = btep_pkg::DIGIT_W;
    localparam int ACC_W  = DW * ((3 * CW + 16 + DW - 1) / DW);
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > 4) ? CNT_W : 4) + 1;
    localparam int ENT_W  = 2 * CW + 32;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SMP     = 5'd1;
    localparam logic [4:0] ST_SMP_DY  = 5'd2;
    localparam logic [4:0] ST_SMP_THR = 5'd3;
    localparam logic [4:0] ST_SMP_CMP = 5'd4;
    localparam logic [4:0] ST_PRD     = 5'd5;
    localparam logic [4:0] ST_PCHK    = 5'd6;
    localparam logic [4:0] ST_TP2     = 5'd7;
    localparam logic [4:0] ST_TP3     = 5'd8;
    localparam logic [4:0] ST_LRD     = 5'd9;
    localparam logic [4:0] ST_LACC    = 5'd10;
    localparam logic [4:0] ST_LXY     = 5'd11;
    localparam logic [4:0] ST_LNXT    = 5'd12;
    localparam logic [4:0] ST_K1      = 5'd13;
    localparam logic [4:0] ST_K2      = 5'd14;
    localparam logic [4:0] ST_K3      = 5'd15;
    localparam logic [4:0] ST_A2      = 5'd16;
    localparam logic [4:0] ST_A3      = 5'd17;
    localparam logic [4:0] ST_B2      = 5'd18;
    localparam logic [4:0] ST_B3      = 5'd19;
    localparam logic [4:0] ST_NORM    = 5'd20;
    localparam logic [4:0] ST_FLAT    = 5'd21;
    localparam logic [4:0] ST_Q1      = 5'd22;
    localparam logic [4:0] ST_Q2      = 5'd23;
    localparam logic [4:0] ST_Y1      = 5'd24;
    localparam logic [4:0] ST_Y2      = 5'd25;
    localparam logic [4:0] ST_EMIT    = 5'd26;
    localparam logic [4:0] ST_MDU     = 5'd27;

    // Configuration registers
    logic [3:0]  r_fit;
    logic [14:0] r_thr;
    logic [23:0] r_stale;
    logic [14:0] r_edge;
    logic [7:0]  r_eps;

    // Control state
    logic [4:0]       r_state;
    logic [4:0]       r_ret;
    logic [IDX_W-1:0] r_newest;
    logic [CNT_W-1:0] r_count;
    logic             r_ovalid;

    // Shared unit request
    logic                    r_mstart;
    logic                    r_mop;
    logic signed [ACC_W-1:0] r_ma;
    logic signed [ACC_W-1:0] r_mb;
    logic signed [ACC_W-1:0] r_res;
    btep_pkg::t_mdu_req      w_mreq;
    logic                    w_mdone;
    logic signed [ACC_W-1:0] w_mres;

    // Latched beat and working registers
    logic signed [CW-1:0]    r_bx;
    logic signed [CW-1:0]    r_by;
    logic [31:0]             r_now;
    logic signed [CW-1:0]    r_x2;
    logic signed [CW-1:0]    r_y2;
    logic                    r_right;
    logic                    r_up;
    logic signed [ACC_W-1:0] r_dx;
    logic signed [ACC_W-1:0] r_dy;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_sx;
    logic signed [ACC_W-1:0] r_sy;
    logic signed [ACC_W-1:0] r_sxx;
    logic signed [ACC_W-1:0] r_sxy;
    logic signed [ACC_W-1:0] r_k;
    logic signed [ACC_W-1:0] r_an;
    logic signed [ACC_W-1:0] r_bn;
    logic signed [ACC_W-1:0] r_px;
    logic signed [ACC_W-1:0] r_py;
    logic signed [CW-1:0]    r_cx;
    logic signed [CW-1:0]    r_cy;
    logic [IDX_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_i;
    logic [CNT_W-1:0]        r_n;
    logic [1:0]              r_status;
    logic [1:0]              r_ostat;
    logic [CW-1:0]           r_ox;
    logic [CW-1:0]           r_oy;

    // History memory
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;
    logic [ENT_W-1:0] w_rdata;
    logic [IDX_W-1:0] w_prev;
    logic [IDX_W-1:0] w_next;
    logic [IDX_W-1:0] w_idx_dec;

    logic signed [CW-1:0]    w_rx;
    logic signed [CW-1:0]    w_ry;
    logic [31:0]             w_rt;
    logic signed [ACC_W-1:0] w_rx_e;
    logic signed [ACC_W-1:0] w_ry_e;
    logic signed [ACC_W-1:0] w_x2_e;
    logic signed [ACC_W-1:0] w_y2_e;
    logic signed [ACC_W-1:0] w_e;
    logic signed [ACC_W-1:0] w_yt;
    logic signed [ACC_W-1:0] w_eps_e;
    logic signed [ACC_W-1:0] w_eps_q;
    logic signed [ACC_W-1:0] w_dx_tp;
    logic signed [ACC_W-1:0] w_dy_tp;
    logic signed [ACC_W-1:0] w_dx_abs;
    logic signed [ACC_W-1:0] w_k3;
    logic signed [ACC_W-1:0] w_k3_abs;
    logic signed [ACC_W-1:0] w_k_abs;
    logic signed [ACC_W-1:0] w_an_abs;
    logic signed [ACC_W-1:0] w_xc;
    logic signed [ACC_W-1:0] w_sat_hi;
    logic signed [ACC_W-1:0] w_sat_lo;
    logic [CW-1:0]           w_ox;
    logic [CW-1:0]           w_oy;
    logic [31:0]             w_age;
    logic                    w_right_c;
    logic                    w_up_c;
    logic                    w_moving;
    logic                    w_too_few;
    logic [CMP_W-1:0]        w_fit_c;
    logic [CMP_W-1:0]        w_cnt_c;
    logic [CMP_W-1:0]        w_need;
    logic [CMP_W-1:0]        w_n;
    logic                    w_in_acc;
    logic                    w_emit_ok;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit   <= btep_pkg::RST_FIT_POINTS;
            r_thr   <= btep_pkg::RST_MOVE_THRESHOLD;
            r_stale <= btep_pkg::RST_STALE_WINDOW;
            r_edge  <= btep_pkg::RST_EDGE_BOUND;
            r_eps   <= btep_pkg::RST_FLAT_EPSILON;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                btep_pkg::CFG_FIT_POINTS:     r_fit   <= i_cfg_wdata[3:0];
                btep_pkg::CFG_MOVE_THRESHOLD: r_thr   <= i_cfg_wdata[14:0];
                btep_pkg::CFG_STALE_WINDOW:   r_stale <= i_cfg_wdata[23:0];
                btep_pkg::CFG_EDGE_BOUND:     r_edge  <= i_cfg_wdata[14:0];
                btep_pkg::CFG_FLAT_EPSILON:   r_eps   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Ring index arithmetic
    assign w_prev    = (r_newest == '0) ? IDX_W'(HISTORY_DEPTH - 1) : r_newest - 1'b1;
    assign w_next    = (r_newest == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign w_idx_dec = (r_idx == '0) ? IDX_W'(HISTORY_DEPTH - 1) : r_idx - 1'b1;

    // Read address follows the sequencer
    always_comb begin
        case (r_state)
            ST_PRD:  w_raddr = w_prev;
            ST_LRD:  w_raddr = r_idx;
            default: w_raddr = r_newest;
        endcase
    end

    // Write the new entry on the first sample or on a recorded move
    assign w_we    = ((r_state == ST_SMP) && (r_count == '0))
                   || ((r_state == ST_SMP_CMP) && (r_acc >= r_res));
    assign w_waddr = (r_state == ST_SMP) ? r_newest : w_next;

    btep_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_now, r_by, r_bx}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_mreq.start = r_mstart;
    assign w_mreq.op    = r_mop;

    btep_mdu #(
        .WIDTH (ACC_W)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mreq),
        .i_a      (r_ma),
        .i_b      (r_mb),
        .o_done   (w_mdone),
        .o_result (w_mres)
    );

    // Entry fields and extended operands
    assign w_rx     = w_rdata[CW-1:0];
    assign w_ry     = w_rdata[2*CW-1:CW];
    assign w_rt     = w_rdata[ENT_W-1:2*CW];
    assign w_rx_e   = ACC_W'(w_rx);
    assign w_ry_e   = ACC_W'(w_ry);
    assign w_x2_e   = ACC_W'(r_x2);
    assign w_y2_e   = ACC_W'(r_y2);
    assign w_e      = $signed(ACC_W'(r_edge));
    assign w_yt     = r_up ? w_e : -w_e;
    assign w_eps_e  = $signed(ACC_W'(r_eps));
    assign w_eps_q  = $signed(ACC_W'({r_eps, {btep_pkg::Q_FRAC{1'b0}}}));

    // Motion check against the previous entry
    assign w_right_c = (r_x2 >= w_rx);
    assign w_up_c    = (r_y2 >= w_ry);
    assign w_age     = r_now - w_rt;
    assign w_moving  = (r_count >= CNT_W'(2)) && ((w_rx != r_x2) || (w_ry != r_y2))
                     && (w_age <= 32'(r_stale));
    assign w_fit_c   = CMP_W'(r_fit);
    assign w_cnt_c   = CMP_W'(r_count);
    assign w_need    = (w_fit_c < CMP_W'(HISTORY_DEPTH)) ? w_fit_c : CMP_W'(HISTORY_DEPTH);
    assign w_too_few = (r_fit > 4'd1) && (w_cnt_c < w_need);
    assign w_n       = (w_fit_c < w_cnt_c) ? w_fit_c : w_cnt_c;

    // Two-point differences and fit magnitudes
    assign w_dx_tp  = w_x2_e - w_rx_e;
    assign w_dy_tp  = w_y2_e - w_ry_e;
    assign w_dx_abs = w_dx_tp[ACC_W-1] ? -w_dx_tp : w_dx_tp;
    assign w_k3     = r_k - r_res;
    assign w_k3_abs = w_k3[ACC_W-1] ? -w_k3 : w_k3;
    assign w_k_abs  = r_k[ACC_W-1] ? -r_k : r_k;
    assign w_an_abs = r_an[ACC_W-1] ? -r_an : r_an;

    // Clamp x to the box, saturate both to the coordinate range
    assign w_sat_hi = $signed(ACC_W'({1'b0, {(CW - 1){1'b1}}}));
    assign w_sat_lo = ~w_sat_hi;
    always_comb begin
        if (r_px > w_e) begin
            w_xc = w_e;
        end else if (r_px < -w_e) begin
            w_xc = -w_e;
        end else begin
            w_xc = r_px;
        end
        if (w_xc > w_sat_hi) begin
            w_ox = w_sat_hi[CW-1:0];
        end else if (w_xc < w_sat_lo) begin
            w_ox = w_sat_lo[CW-1:0];
        end else begin
            w_ox = w_xc[CW-1:0];
        end
        if (r_py > w_sat_hi) begin
            w_oy = w_sat_hi[CW-1:0];
        end else if (r_py < w_sat_lo) begin
            w_oy = w_sat_lo[CW-1:0];
        end else begin
            w_oy = r_py[CW-1:0];
        end
    end

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_emit_ok = !r_ovalid || m_axis_tready;

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_newest <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_bx    <= s_axis_tdata[CW-1:0];
                        r_by    <= s_axis_tdata[2*CW-1:CW];
                        r_now   <= s_axis_tdata[2*CW+31:2*CW];
                        r_state <= (s_axis_tuser == btep_pkg::KIND_SAMPLE) ? ST_SMP : ST_PRD;
                    end
                end
                ST_SMP: begin
                    if (r_count == '0) begin
                        r_count <= CNT_W'(1);
                        r_state <= ST_IDLE;
                    end else begin
                        r_dx     <= ACC_W'(r_bx) - w_rx_e;
                        r_dy     <= ACC_W'(r_by) - w_ry_e;
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= ACC_W'(r_bx) - w_rx_e;
                        r_mb     <= ACC_W'(r_bx) - w_rx_e;
                        r_ret    <= ST_SMP_DY;
                        r_state  <= ST_MDU;
                    end
                end
                ST_SMP_DY: begin
                    r_acc    <= r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_dy;
                    r_mb     <= r_dy;
                    r_ret    <= ST_SMP_THR;
                    r_state  <= ST_MDU;
                end
                ST_SMP_THR: begin
                    r_acc    <= r_acc + r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= $signed(ACC_W'(r_thr));
                    r_mb     <= $signed(ACC_W'(r_thr));
                    r_ret    <= ST_SMP_CMP;
                    r_state  <= ST_MDU;
                end
                ST_SMP_CMP: begin
                    // record only when the move reaches the threshold
                    if (r_acc >= r_res) begin
                        r_newest <= w_next;
                        if (r_count != CNT_W'(HISTORY_DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                ST_PRD: begin
                    r_x2 <= w_rx;
                    r_y2 <= w_ry;
                    if (r_count == '0) begin
                        r_status <= btep_pkg::STAT_FEW;
                        r_px     <= '0;
                        r_py     <= '0;
                        r_state  <= ST_EMIT;
                    end else begin
                        r_state <= ST_PCHK;
                    end
                end
                ST_PCHK: begin
                    r_right  <= w_right_c;
                    r_up     <= w_up_c;
                    r_status <= btep_pkg::STAT_OK;
                    if (!w_moving) begin
                        r_count  <= CNT_W'(1);
                        r_status <= btep_pkg::STAT_STILL;
                        r_px     <= '0;
                        r_py     <= '0;
                        r_state  <= ST_EMIT;
                    end else if (w_too_few) begin
                        r_status <= btep_pkg::STAT_FEW;
                        r_px     <= '0;
                        r_py     <= '0;
                        r_state  <= ST_EMIT;
                    end else if (r_fit > 4'd1) begin
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sxx   <= '0;
                        r_sxy   <= '0;
                        r_idx   <= r_newest;
                        r_i     <= '0;
                        r_n     <= w_n[CNT_W-1:0];
                        r_state <= ST_LRD;
                    end else if (w_dx_abs <= w_eps_e) begin
                        // vertical fallback
                        r_px    <= w_x2_e;
                        r_py    <= w_up_c ? w_e : -w_e;
                        r_state <= ST_EMIT;
                    end else begin
                        r_k      <= w_dx_tp;
                        r_an     <= w_dy_tp;
                        r_dy     <= w_dy_tp;
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= w_y2_e;
                        r_mb     <= w_dx_tp;
                        r_ret    <= ST_TP2;
                        r_state  <= ST_MDU;
                    end
                end
                ST_TP2: begin
                    r_bn     <= r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_dy;
                    r_mb     <= w_x2_e;
                    r_ret    <= ST_TP3;
                    r_state  <= ST_MDU;
                end
                ST_TP3: begin
                    r_bn    <= r_bn - r_res;
                    r_state <= ST_NORM;
                end
                ST_LRD: begin
                    r_state <= ST_LACC;
                end
                ST_LACC: begin
                    r_cx     <= w_rx;
                    r_cy     <= w_ry;
                    r_sx     <= r_sx + w_rx_e;
                    r_sy     <= r_sy + w_ry_e;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= w_rx_e;
                    r_mb     <= w_rx_e;
                    r_ret    <= ST_LXY;
                    r_state  <= ST_MDU;
                end
                ST_LXY: begin
                    r_sxx    <= r_sxx + r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= ACC_W'(r_cx);
                    r_mb     <= ACC_W'(r_cy);
                    r_ret    <= ST_LNXT;
                    r_state  <= ST_MDU;
                end
                ST_LNXT: begin
                    r_sxy <= r_sxy + r_res;
                    r_i   <= r_i + 1'b1;
                    r_idx <= w_idx_dec;
                    if ((r_i + 1'b1) == r_n) begin
                        r_state <= ST_K1;
                    end else begin
                        r_state <= ST_LRD;
                    end
                end
                ST_K1: begin
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= $signed(ACC_W'(r_n));
                    r_mb     <= r_sxx;
                    r_ret    <= ST_K2;
                    r_state  <= ST_MDU;
                end
                ST_K2: begin
                    r_k      <= r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_sx;
                    r_mb     <= r_sx;
                    r_ret    <= ST_K3;
                    r_state  <= ST_MDU;
                end
                ST_K3: begin
                    r_k <= w_k3;
                    if (w_k3_abs <= w_eps_q) begin
                        // singular fit: vertical fallback
                        r_px    <= w_x2_e;
                        r_py    <= w_yt;
                        r_state <= ST_EMIT;
                    end else begin
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= $signed(ACC_W'(r_n));
                        r_mb     <= r_sxy;
                        r_ret    <= ST_A2;
                        r_state  <= ST_MDU;
                    end
                end
                ST_A2: begin
                    r_an     <= r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_sx;
                    r_mb     <= r_sy;
                    r_ret    <= ST_A3;
                    r_state  <= ST_MDU;
                end
                ST_A3: begin
                    r_an     <= r_an - r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_sxx;
                    r_mb     <= r_sy;
                    r_ret    <= ST_B2;
                    r_state  <= ST_MDU;
                end
                ST_B2: begin
                    r_bn     <= r_res;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= r_sx;
                    r_mb     <= r_sxy;
                    r_ret    <= ST_B3;
                    r_state  <= ST_MDU;
                end
                ST_B3: begin
                    r_bn    <= r_bn - r_res;
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    // make the denominator positive
                    if (r_k[ACC_W-1]) begin
                        r_an <= -r_an;
                        r_bn <= -r_bn;
                    end
                    r_k      <= w_k_abs;
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_MUL;
                    r_ma     <= w_eps_e;
                    r_mb     <= w_k_abs;
                    r_ret    <= ST_FLAT;
                    r_state  <= ST_MDU;
                end
                ST_FLAT: begin
                    if ((w_an_abs <<< btep_pkg::Q_FRAC) <= r_res) begin
                        // flat slope
                        r_px    <= r_right ? w_e : -w_e;
                        r_py    <= w_y2_e;
                        r_state <= ST_EMIT;
                    end else begin
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= w_yt;
                        r_mb     <= r_k;
                        r_ret    <= ST_Q1;
                        r_state  <= ST_MDU;
                    end
                end
                ST_Q1: begin
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_DIV;
                    r_ma     <= r_res - r_bn;
                    r_mb     <= r_an;
                    r_ret    <= ST_Q2;
                    r_state  <= ST_MDU;
                end
                ST_Q2: begin
                    if (r_right && (r_res > w_e)) begin
                        r_px     <= w_e;
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= r_an;
                        r_mb     <= w_e;
                        r_ret    <= ST_Y1;
                        r_state  <= ST_MDU;
                    end else if (!r_right && (r_res < -w_e)) begin
                        r_px     <= -w_e;
                        r_mstart <= 1'b1;
                        r_mop    <= btep_pkg::MDU_MUL;
                        r_ma     <= r_an;
                        r_mb     <= -w_e;
                        r_ret    <= ST_Y1;
                        r_state  <= ST_MDU;
                    end else begin
                        r_px    <= r_res;
                        r_py    <= w_yt;
                        r_state <= ST_EMIT;
                    end
                end
                ST_Y1: begin
                    r_mstart <= 1'b1;
                    r_mop    <= btep_pkg::MDU_DIV;
                    r_ma     <= r_res + r_bn;
                    r_mb     <= r_k;
                    r_ret    <= ST_Y2;
                    r_state  <= ST_MDU;
                end
                ST_Y2: begin
                    r_py    <= r_res;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (w_emit_ok) begin
                        r_ostat  <= r_status;
                        r_ox     <= w_ox;
                        r_oy     <= w_oy;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_MDU: begin
                    if (w_mdone) begin
                        r_res   <= w_mres;
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'({r_oy, r_ox});
    assign m_axis_tuser  = r_ostat;

endmodule

// ===== tb/tb_ball_trajectory_edge_predictor.sv =====
module tb_ball_trajectory_edge_predictor;
    import btep_pkg::*;

    localparam int DEPTH = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] px;
        logic [15:0] py;
    } edge_point_t;

    // Tracks the ball history and predicts the edge point of each predict beat
    class edge_scoreboard;
        logic [3:0]  fit_n;
        logic [14:0] thr;
        logic [23:0] stale;
        logic [14:0] bound;
        logic [7:0]  eps;
        logic signed [15:0] hx[DEPTH];
        logic signed [15:0] hy[DEPTH];
        logic [31:0] ht[DEPTH];
        int newest;
        int count;
        edge_point_t pending[$];
        int errors;

        function void clear();
            fit_n = RST_FIT_POINTS;
            thr = RST_MOVE_THRESHOLD;
            stale = RST_STALE_WINDOW;
            bound = RST_EDGE_BOUND;
            eps = RST_FLAT_EPSILON;
            newest = 0;
            count = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_FIT_POINTS:     fit_n = v[3:0];
                CFG_MOVE_THRESHOLD: thr = v[14:0];
                CFG_STALE_WINDOW:   stale = v[23:0];
                CFG_EDGE_BOUND:     bound = v[14:0];
                CFG_FLAT_EPSILON:   eps = v[7:0];
                default: ;
            endcase
        endfunction

        // Line fit over the newest entries (two-point line when fit_n is at most 1), then intersect with the box
        function void fit_edge(output longint x, output longint y);
            int i2, i1, n, j;
            longint x1, y1, x2, y2, e, ep, an, bn, k, sx, sy, sxx, sxy, dx, dy, yt, q;
            bit right, up, vert;
            i2 = newest;
            i1 = (newest + DEPTH - 1) % DEPTH;
            x1 = hx[i1]; y1 = hy[i1]; x2 = hx[i2]; y2 = hy[i2];
            right = x2 >= x1;
            up = y2 >= y1;
            e = bound;
            ep = eps;
            an = 0; bn = 0; k = 0; vert = 0;
            if (fit_n > 1) begin
                n = (fit_n < count) ? fit_n : count;
                sx = 0; sy = 0; sxx = 0; sxy = 0;
                for (int i = 0; i < n; i++) begin
                    j = (newest + DEPTH - i) % DEPTH;
                    sx += hx[j];
                    sy += hy[j];
                    sxx += longint'(hx[j]) * hx[j];
                    sxy += longint'(hx[j]) * hy[j];
                end
                k = n * sxx - sx * sx;
                if ((k < 0 ? -k : k) <= ep * 16384) vert = 1;
                else begin
                    an = n * sxy - sx * sy;
                    bn = sxx * sy - sx * sxy;
                end
            end else begin
                dx = x2 - x1;
                dy = y2 - y1;
                if ((dx < 0 ? -dx : dx) <= ep) vert = 1;
                else begin
                    k = dx;
                    an = dy;
                    bn = y2 * dx - dy * x2;
                end
            end
            if (vert) begin
                x = x2;
                y = up ? e : -e;
            end else begin
                if (k < 0) begin
                    k = -k; an = -an; bn = -bn;
                end
                if ((an < 0 ? -an : an) * 16384 <= ep * k) begin
                    x = right ? e : -e;
                    y = y2;
                end else begin
                    yt = up ? e : -e;
                    q = (yt * k - bn) / an;
                    if (right && q > e) begin
                        x = e;
                        y = (an * e + bn) / k;
                    end else if (!right && q < -e) begin
                        x = -e;
                        y = (an * -e + bn) / k;
                    end else begin
                        x = q;
                        y = yt;
                    end
                end
            end
            if (x > e) x = e;
            if (x < -e) x = -e;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
        endfunction

        function void note_item(logic kind, logic signed [15:0] bx, logic signed [15:0] by,
                                logic [31:0] now);
            longint dx, dy, px, py;
            int i1;
            logic [31:0] dt;
            edge_point_t r;
            if (kind == KIND_SAMPLE) begin
                if (count != 0) begin
                    dx = longint'(bx) - hx[newest];
                    dy = longint'(by) - hy[newest];
                    if (dx * dx + dy * dy < longint'(thr) * thr) return;
                    newest = (newest + 1) % DEPTH;
                end
                hx[newest] = bx;
                hy[newest] = by;
                ht[newest] = now;
                if (count < DEPTH) count++;
                return;
            end
            r = '0;
            if (count == 0) r.status = STAT_FEW;
            else begin
                i1 = (newest + DEPTH - 1) % DEPTH;
                dt = now - ht[i1];
                if (count < 2 || (hx[i1] == hx[newest] && hy[i1] == hy[newest])
                    || dt > stale) begin
                    count = 1;
                    r.status = STAT_STILL;
                end else if (fit_n > 1 && count < ((fit_n < DEPTH) ? fit_n : DEPTH)) begin
                    r.status = STAT_FEW;
                end else begin
                    fit_edge(px, py);
                    r.status = STAT_OK;
                    r.px = px[15:0];
                    r.py = py[15:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [15:0] px, logic [15:0] py);
            edge_point_t w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat st=%0d x=%0d y=%0d",
                                           st, $signed(px), $signed(py));
                return;
            end
            w = pending.pop_front();
            if (w.status !== st || w.px !== px || w.py !== py) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d x=%0d y=%0d, got st=%0d x=%0d y=%0d",
                             w.status, $signed(w.px), $signed(w.py),
                             st, $signed(px), $signed(py));
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    edge_scoreboard sb = new();
    logic [31:0] tnow = 0;
    bit quiet = 0;
    int gap_pct = 15;
    int stall_left = 0;

    ball_trajectory_edge_predictor dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check accepted beats, stall in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 0;
            end else if (!quiet && i_rst_n && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic send_item(logic kind, logic [15:0] bx, logic [15:0] by, logic [31:0] now);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {now, by, bx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, bx, by, now);
    endtask

    task automatic sample_at(int bx, int by, int dt);
        tnow += dt;
        send_item(KIND_SAMPLE, bx[15:0], by[15:0], tnow);
    endtask

    task automatic predict_at(int dt);
        tnow += dt;
        send_item(KIND_PREDICT, $urandom, $urandom, tnow);
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int v);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.write_reg(idx, v[CFG_DATA_W-1:0]);
        i_cfg_we <= 0;
    endtask

    // Sampled straight-line run followed by a predict
    task automatic trajectory();
        int x0, y0, vx, vy, m;
        x0 = $urandom_range(0, 32000) - 16000;
        y0 = $urandom_range(0, 32000) - 16000;
        vx = $urandom_range(0, 3000) - 1500;
        vy = $urandom_range(0, 3000) - 1500;
        if ($urandom_range(0, 9) == 0) vx = $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 9) == 0) vy = $urandom_range(0, 4) - 2;
        m = $urandom_range(1, 12);
        for (int i = 0; i < m; i++)
            sample_at(x0 + i * vx + $urandom_range(0, 6) - 3,
                      y0 + i * vy + $urandom_range(0, 6) - 3, $urandom_range(1, 2000));
        predict_at($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 2000));
    endtask

    initial begin
        int done;
        sb.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty, single entry, extremes, stale, equal entries
        predict_at(5);
        sample_at(-32768, 32767, 10);
        predict_at(10);
        sample_at(32767, -32768, 10);
        predict_at(10);
        predict_at(200000);
        drain();
        write_reg(CFG_FIT_POINTS, 1);
        write_reg(CFG_MOVE_THRESHOLD, 0);
        sample_at(0, 0, 10);
        sample_at(0, 0, 10);
        predict_at(5);
        sample_at(8000, 4000, 10);
        predict_at(5);
        sample_at(8001, 12000, 10);
        predict_at(5);
        sample_at(16000, 12000, 10);
        predict_at(5);
        drain();
        write_reg(CFG_FIT_POINTS, 10);
        for (int i = 0; i < 10; i++) sample_at(-9000 + 1700 * i, 3000 - 900 * i, 50);
        predict_at(5);
        drain();
        write_reg(CFG_FIT_POINTS, 0);
        predict_at(5);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                write_reg(CFG_FIT_POINTS, 0);
                write_reg(CFG_MOVE_THRESHOLD, 0);
                write_reg(CFG_STALE_WINDOW, 0);
                write_reg(CFG_EDGE_BOUND, 0);
                write_reg(CFG_FLAT_EPSILON, 0);
            end else if (p == 1) begin
                write_reg(CFG_FIT_POINTS, 15);
                write_reg(CFG_MOVE_THRESHOLD, 32767);
                write_reg(CFG_STALE_WINDOW, 24'hFFFFFF);
                write_reg(CFG_EDGE_BOUND, 16384);
                write_reg(CFG_FLAT_EPSILON, 255);
            end else begin
                write_reg(CFG_FIT_POINTS, $urandom_range(0, 15));
                write_reg(CFG_MOVE_THRESHOLD, $urandom_range(0, 9) == 0 ?
                          $urandom_range(0, 32767) : $urandom_range(0, 1500));
                write_reg(CFG_STALE_WINDOW, $urandom_range(0, 9) == 0 ?
                          $urandom_range(0, 3000) : $urandom_range(0, 24'hFFFFFF));
                write_reg(CFG_EDGE_BOUND, $urandom_range(0, 16384));
                write_reg(CFG_FLAT_EPSILON, $urandom_range(0, 255));
            end
            gap_pct = (p % 3 == 2) ? 0 : 15;
            quiet = (p == 7);
            done = 0;
            while (done < 50) begin
                if ($urandom_range(0, 9) < 8) begin
                    trajectory();
                    done += 4;
                end else begin
                    send_item($urandom_range(0, 1), $urandom, $urandom, $urandom);
                    done++;
                end
                if (p == 3 && done > 20 && done < 25) drain();
            end
            drain();
        end

        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
